@@ sv/ke2ps2_pkg.sv @@
// Package: key code table, sequence kinds and shared types for the set 2 converter.
`timescale 1ns / 1ps
package ke2ps2_pkg;

  localparam int unsigned KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NORM  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EXT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PRTSC = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PAUSE = 3'd4;

  localparam logic [7:0] BYTE_BREAK = 8'hF0;
  localparam logic [7:0] BYTE_EXT0  = 8'hE0;
  localparam logic [7:0] BYTE_EXT1  = 8'hE1;
  localparam logic [7:0] BYTE_LCTRL = 8'h14;
  localparam logic [7:0] BYTE_NUML  = 8'h77;
  localparam logic [7:0] BYTE_LSHFT = 8'h12;
  localparam logic [7:0] BYTE_KPMUL = 8'h7C;

  localparam logic [7:0] HID_PRTSC = 8'h46;
  localparam logic [7:0] HID_PAUSE = 8'h48;

  localparam int unsigned SEQ_MAX = 8;
  localparam int unsigned IDX_W   = $clog2(SEQ_MAX);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        code;
  } entry_t;

  typedef struct packed {
    entry_t entry;
    logic   rel;
  } item_t;

  function automatic entry_t make_entry(input logic [7:0] key);
    entry_t e;
    e.kind = KIND_NORM;
    e.code = 8'h00;
    case (key)
      8'h04: e.code = 8'h1C;  8'h05: e.code = 8'h32;  8'h06: e.code = 8'h21;
      8'h07: e.code = 8'h23;  8'h08: e.code = 8'h24;  8'h09: e.code = 8'h2B;
      8'h0A: e.code = 8'h34;  8'h0B: e.code = 8'h33;  8'h0C: e.code = 8'h43;
      8'h0D: e.code = 8'h3B;  8'h0E: e.code = 8'h42;  8'h0F: e.code = 8'h4B;
      8'h10: e.code = 8'h3A;  8'h11: e.code = 8'h31;  8'h12: e.code = 8'h44;
      8'h13: e.code = 8'h4D;  8'h14: e.code = 8'h15;  8'h15: e.code = 8'h2D;
      8'h16: e.code = 8'h1B;  8'h17: e.code = 8'h2C;  8'h18: e.code = 8'h3C;
      8'h19: e.code = 8'h2A;  8'h1A: e.code = 8'h1D;  8'h1B: e.code = 8'h22;
      8'h1C: e.code = 8'h35;  8'h1D: e.code = 8'h1A;  8'h1E: e.code = 8'h16;
      8'h1F: e.code = 8'h1E;  8'h20: e.code = 8'h26;  8'h21: e.code = 8'h25;
      8'h22: e.code = 8'h2E;  8'h23: e.code = 8'h36;  8'h24: e.code = 8'h3D;
      8'h25: e.code = 8'h3E;  8'h26: e.code = 8'h46;  8'h27: e.code = 8'h45;
      8'h28: e.code = 8'h5A;  8'h29: e.code = 8'h76;  8'h2A: e.code = 8'h66;
      8'h2B: e.code = 8'h0D;  8'h2C: e.code = 8'h29;  8'h2D: e.code = 8'h4E;
      8'h2E: e.code = 8'h55;  8'h2F: e.code = 8'h54;  8'h30: e.code = 8'h5B;
      8'h31: e.code = 8'h5D;  8'h33: e.code = 8'h4C;  8'h34: e.code = 8'h52;
      8'h35: e.code = 8'h0E;  8'h36: e.code = 8'h41;  8'h37: e.code = 8'h49;
      8'h38: e.code = 8'h4A;  8'h39: e.code = 8'h58;  8'h3A: e.code = 8'h05;
      8'h3B: e.code = 8'h06;  8'h3C: e.code = 8'h04;  8'h3D: e.code = 8'h0C;
      8'h3E: e.code = 8'h03;  8'h3F: e.code = 8'h0B;  8'h40: e.code = 8'h83;
      8'h41: e.code = 8'h0A;  8'h42: e.code = 8'h01;  8'h43: e.code = 8'h09;
      8'h44: e.code = 8'h78;  8'h45: e.code = 8'h07;  8'h47: e.code = 8'h7E;
      8'h53: e.code = 8'h77;  8'h55: e.code = 8'h7C;  8'h56: e.code = 8'h7B;
      8'h57: e.code = 8'h79;  8'h59: e.code = 8'h69;  8'h5A: e.code = 8'h72;
      8'h5B: e.code = 8'h7A;  8'h5C: e.code = 8'h6B;  8'h5D: e.code = 8'h73;
      8'h5E: e.code = 8'h74;  8'h5F: e.code = 8'h6C;  8'h60: e.code = 8'h75;
      8'h61: e.code = 8'h7D;  8'h62: e.code = 8'h70;  8'h63: e.code = 8'h71;
      8'hE0: e.code = 8'h14;  8'hE1: e.code = 8'h12;  8'hE2: e.code = 8'h11;
      8'hE5: e.code = 8'h59;
      8'h49: e = '{kind: KIND_EXT, code: 8'h70};
      8'h4A: e = '{kind: KIND_EXT, code: 8'h6C};
      8'h4B: e = '{kind: KIND_EXT, code: 8'h7D};
      8'h4C: e = '{kind: KIND_EXT, code: 8'h71};
      8'h4D: e = '{kind: KIND_EXT, code: 8'h69};
      8'h4E: e = '{kind: KIND_EXT, code: 8'h7A};
      8'h4F: e = '{kind: KIND_EXT, code: 8'h74};
      8'h50: e = '{kind: KIND_EXT, code: 8'h6B};
      8'h51: e = '{kind: KIND_EXT, code: 8'h72};
      8'h52: e = '{kind: KIND_EXT, code: 8'h75};
      8'h54: e = '{kind: KIND_EXT, code: 8'h4A};
      8'h58: e = '{kind: KIND_EXT, code: 8'h5A};
      8'h65: e = '{kind: KIND_EXT, code: 8'h2F};
      8'hE3: e = '{kind: KIND_EXT, code: 8'h1F};
      8'hE4: e = '{kind: KIND_EXT, code: 8'h14};
      8'hE6: e = '{kind: KIND_EXT, code: 8'h11};
      8'hE7: e = '{kind: KIND_EXT, code: 8'h27};
      HID_PRTSC: e.kind = KIND_PRTSC;
      HID_PAUSE: e.kind = KIND_PAUSE;
      default:   e.kind = KIND_NONE;
    endcase
    return e;
  endfunction

endpackage

@@ sv/ke2ps2_seq.sv @@
// Byte sequencer: expands one looked-up key event into its set 2 bytes, one beat per cycle.
`timescale 1ns / 1ps
module ke2ps2_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  ke2ps2_pkg::item_t    item,
  output logic                 take,
  output logic                 out_strobe,
  output logic [7:0]           out_scan_byte,
  output logic                 out_last_byte
);
  import ke2ps2_pkg::*;

  logic [7:0]       seq_r [SEQ_MAX];
  logic [7:0]       seq_nxt [SEQ_MAX];
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] last_r;
  logic [IDX_W-1:0] last_nxt;
  logic             act_r;
  logic             has_nxt;
  logic             strobe_r;
  logic [7:0]       byte_r;
  logic             lastb_r;
  logic             at_end;

  assign at_end = (idx_r == last_r);
  assign take   = item_valid && (!act_r || at_end);

  always_comb begin
    for (int i = 0; i < SEQ_MAX; i++) seq_nxt[i] = 8'h00;
    last_nxt = '0;
    has_nxt  = 1'b1;
    case (item.entry.kind)
      KIND_NORM: begin
        if (item.rel) begin
          seq_nxt[0] = BYTE_BREAK;
          seq_nxt[1] = item.entry.code;
          last_nxt   = IDX_W'(1);
        end else begin
          seq_nxt[0] = item.entry.code;
        end
      end
      KIND_EXT: begin
        seq_nxt[0] = BYTE_EXT0;
        if (item.rel) begin
          seq_nxt[1] = BYTE_BREAK;
          seq_nxt[2] = item.entry.code;
          last_nxt   = IDX_W'(2);
        end else begin
          seq_nxt[1] = item.entry.code;
          last_nxt   = IDX_W'(1);
        end
      end
      KIND_PRTSC: begin
        seq_nxt[0] = BYTE_EXT0;
        if (item.rel) begin
          seq_nxt[1] = BYTE_BREAK;
          seq_nxt[2] = BYTE_KPMUL;
          seq_nxt[3] = BYTE_EXT0;
          seq_nxt[4] = BYTE_BREAK;
          seq_nxt[5] = BYTE_LSHFT;
          last_nxt   = IDX_W'(5);
        end else begin
          seq_nxt[1] = BYTE_LSHFT;
          seq_nxt[2] = BYTE_EXT0;
          seq_nxt[3] = BYTE_KPMUL;
          last_nxt   = IDX_W'(3);
        end
      end
      KIND_PAUSE: begin
        seq_nxt[0] = BYTE_EXT1;
        seq_nxt[1] = BYTE_LCTRL;
        seq_nxt[2] = BYTE_NUML;
        seq_nxt[3] = BYTE_EXT1;
        seq_nxt[4] = BYTE_BREAK;
        seq_nxt[5] = BYTE_LCTRL;
        seq_nxt[6] = BYTE_BREAK;
        seq_nxt[7] = BYTE_NUML;
        last_nxt   = IDX_W'(SEQ_MAX - 1);
        has_nxt    = !item.rel;
      end
      default: has_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      strobe_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      strobe_r <= act_r;
      if (take) begin
        act_r  <= has_nxt;
        idx_r  <= '0;
        last_r <= last_nxt;
        seq_r  <= seq_nxt;
      end else if (act_r) begin
        idx_r <= idx_r + 1'b1;
        if (at_end) act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= seq_r[idx_r];
    lastb_r <= at_end;
  end

  assign out_strobe    = strobe_r;
  assign out_scan_byte = byte_r;
  assign out_last_byte = lastb_r;

endmodule

@@ sv/key_event_to_ps2_set2_bytes.sv @@
// Top level: USB HID key event in, PS/2 scan code set 2 bytes out.
`timescale 1ns / 1ps
// A key event is taken when start is high and busy is low. Its key code is
// looked up in a registered table, then its bytes leave one beat per clock
// on out_scan_byte, flagged by out_strobe, with out_last_byte on the final
// one. The first byte passes through the lookup register, the sequencer's
// byte store and its output register. An event has 1 to 8 bytes (Print
// Screen 4 or 6, Pause press 8); an event with no bytes (unmapped key,
// Pause release) passes through the lookup register and sends nothing.
// A waiting event is taken while the current one is still streaming, so
// sequences follow each other with no gap. The receiver cannot stall:
// every strobed byte must be captured in its cycle.
module key_event_to_ps2_set2_bytes (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_key_code,
  input  logic       in_released,
  output logic       out_strobe,
  output logic [7:0] out_scan_byte,
  output logic       out_last_byte
);
  import ke2ps2_pkg::*;

  logic  s1_valid_r;
  item_t s1_item_r;
  logic  take;
  logic  accept;

  assign busy   = s1_valid_r && !take;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (take) begin
      s1_valid_r <= 1'b0;
    end
  end

  // table read, registered
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.entry <= make_entry(in_key_code);
      s1_item_r.rel   <= in_released;
    end
  end

  ke2ps2_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (s1_valid_r),
    .item          (s1_item_r),
    .take          (take),
    .out_strobe    (out_strobe),
    .out_scan_byte (out_scan_byte),
    .out_last_byte (out_last_byte)
  );

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_byte |=> out_strobe)
    else $error("byte sequence broken before its last beat");

  a_e0_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_scan_byte == BYTE_EXT0 || out_scan_byte == BYTE_EXT1)
      |-> !out_last_byte)
    else $error("prefix byte flagged as last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe && !busy)
    else $error("activity right after reset");

  a_busy_held: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> s1_valid_r && !take)
    else $error("busy without a pending event");

endmodule

@@ bench/key_event_to_ps2_set2_bytes_test.sv @@
// Testbench: key events in, set 2 byte beats checked against a table-driven predictor.
`timescale 1ns / 1ps
module key_event_to_ps2_set2_bytes_test;
  import ke2ps2_pkg::*;

  localparam int RANDOM_EVENTS = 235;
  localparam int STALL_LIMIT   = 200;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        make;
  } set2_key_t;

  typedef struct packed {
    logic [7:0] key;
    logic       rel;
    logic       golden;
    logic [3:0] n;
    logic [63:0] seq;
  } key_row_t;

  typedef struct packed {
    logic [7:0] scan;
    logic       last;
  } set2_byte_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_key_code;
  logic       in_released;
  logic       out_strobe;
  logic [7:0] out_scan_byte;
  logic       out_last_byte;

  set2_key_t  set2_map [256];
  key_row_t   event_rows[$];
  set2_byte_t pending_bytes[$];
  set2_byte_t want_byte;
  int         mismatch_count;
  int         accepted_events;
  int         bytes_seen;
  int         last_activity;
  int         stall_cycles;

  key_event_to_ps2_set2_bytes dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_key_code  (in_key_code),
    .in_released  (in_released),
    .out_strobe   (out_strobe),
    .out_scan_byte(out_scan_byte),
    .out_last_byte(out_last_byte)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void norm_key(input logic [7:0] k, input logic [7:0] code);
    set2_map[k] = '{KIND_NORM, code};
  endfunction

  function automatic void ext_key(input logic [7:0] k, input logic [7:0] code);
    set2_map[k] = '{KIND_EXT, code};
  endfunction

  // Appends one byte; the sequence is right-aligned, first byte highest.
  function automatic void put_byte(inout logic [63:0] s, inout int n, input logic [7:0] b);
    s = {s[55:0], b};
    n++;
  endfunction

  function automatic int predict_set2(input logic [7:0] k, input logic rel,
                                      output logic [63:0] seq);
    int n;
    n = 0;
    seq = '0;
    if (k == HID_PRTSC) begin
      if (rel) begin
        put_byte(seq, n, BYTE_EXT0);
        put_byte(seq, n, BYTE_BREAK);
        put_byte(seq, n, BYTE_KPMUL);
        put_byte(seq, n, BYTE_EXT0);
        put_byte(seq, n, BYTE_BREAK);
        put_byte(seq, n, BYTE_LSHFT);
      end else begin
        put_byte(seq, n, BYTE_EXT0);
        put_byte(seq, n, BYTE_LSHFT);
        put_byte(seq, n, BYTE_EXT0);
        put_byte(seq, n, BYTE_KPMUL);
      end
    end else if (k == HID_PAUSE) begin
      if (!rel) begin
        put_byte(seq, n, BYTE_EXT1);
        put_byte(seq, n, BYTE_LCTRL);
        put_byte(seq, n, BYTE_NUML);
        put_byte(seq, n, BYTE_EXT1);
        put_byte(seq, n, BYTE_BREAK);
        put_byte(seq, n, BYTE_LCTRL);
        put_byte(seq, n, BYTE_BREAK);
        put_byte(seq, n, BYTE_NUML);
      end
    end else if (set2_map[k].kind != KIND_NONE) begin
      if (set2_map[k].kind == KIND_EXT) put_byte(seq, n, BYTE_EXT0);
      if (rel) put_byte(seq, n, BYTE_BREAK);
      put_byte(seq, n, set2_map[k].make);
    end
    return n;
  endfunction

  function automatic void add_row(input logic [7:0] k, input logic rel, input logic golden,
                                  input int n, input logic [63:0] seq);
    event_rows.push_back('{k, rel, golden, n[3:0], seq});
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %02h last=%b", out_scan_byte,
                                  out_last_byte));
      end else begin
        want_byte = pending_bytes.pop_front();
        if (out_scan_byte !== want_byte.scan)
          report_mismatch($sformatf("scan_byte %02h, want %02h", out_scan_byte, want_byte.scan));
        if (out_last_byte !== want_byte.last)
          report_mismatch($sformatf("last_byte %b, want %b (byte %02h)", out_last_byte,
                                    want_byte.last, want_byte.scan));
      end
    end
  end

  always @(posedge clk) begin
    if (accepted_events + bytes_seen != last_activity) begin
      last_activity = accepted_events + bytes_seen;
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    key_row_t   row;
    logic [63:0] seq;
    logic [7:0] k;
    int         n;
    int         pick;
    int         burst_left;
    int         directed_rows;

    rst_n = 1'b0;
    start = 1'b0;
    in_key_code = 8'h00;
    in_released = 1'b0;
    mismatch_count = 0;
    accepted_events = 0;
    bytes_seen = 0;
    last_activity = 0;
    stall_cycles = 0;

    foreach (set2_map[i]) set2_map[i] = '{KIND_NONE, 8'h00};
    norm_key(8'h04, 8'h1C); norm_key(8'h05, 8'h32); norm_key(8'h06, 8'h21); norm_key(8'h07, 8'h23);
    norm_key(8'h08, 8'h24); norm_key(8'h09, 8'h2B); norm_key(8'h0A, 8'h34); norm_key(8'h0B, 8'h33);
    norm_key(8'h0C, 8'h43); norm_key(8'h0D, 8'h3B); norm_key(8'h0E, 8'h42); norm_key(8'h0F, 8'h4B);
    norm_key(8'h10, 8'h3A); norm_key(8'h11, 8'h31); norm_key(8'h12, 8'h44); norm_key(8'h13, 8'h4D);
    norm_key(8'h14, 8'h15); norm_key(8'h15, 8'h2D); norm_key(8'h16, 8'h1B); norm_key(8'h17, 8'h2C);
    norm_key(8'h18, 8'h3C); norm_key(8'h19, 8'h2A); norm_key(8'h1A, 8'h1D); norm_key(8'h1B, 8'h22);
    norm_key(8'h1C, 8'h35); norm_key(8'h1D, 8'h1A); norm_key(8'h1E, 8'h16); norm_key(8'h1F, 8'h1E);
    norm_key(8'h20, 8'h26); norm_key(8'h21, 8'h25); norm_key(8'h22, 8'h2E); norm_key(8'h23, 8'h36);
    norm_key(8'h24, 8'h3D); norm_key(8'h25, 8'h3E); norm_key(8'h26, 8'h46); norm_key(8'h27, 8'h45);
    norm_key(8'h28, 8'h5A); norm_key(8'h29, 8'h76); norm_key(8'h2A, 8'h66); norm_key(8'h2B, 8'h0D);
    norm_key(8'h2C, 8'h29); norm_key(8'h2D, 8'h4E); norm_key(8'h2E, 8'h55); norm_key(8'h2F, 8'h54);
    norm_key(8'h30, 8'h5B); norm_key(8'h31, 8'h5D); norm_key(8'h33, 8'h4C); norm_key(8'h34, 8'h52);
    norm_key(8'h35, 8'h0E); norm_key(8'h36, 8'h41); norm_key(8'h37, 8'h49); norm_key(8'h38, 8'h4A);
    norm_key(8'h39, 8'h58); norm_key(8'h3A, 8'h05); norm_key(8'h3B, 8'h06); norm_key(8'h3C, 8'h04);
    norm_key(8'h3D, 8'h0C); norm_key(8'h3E, 8'h03); norm_key(8'h3F, 8'h0B); norm_key(8'h40, 8'h83);
    norm_key(8'h41, 8'h0A); norm_key(8'h42, 8'h01); norm_key(8'h43, 8'h09); norm_key(8'h44, 8'h78);
    norm_key(8'h45, 8'h07); norm_key(8'h47, 8'h7E); norm_key(8'h53, 8'h77); norm_key(8'h55, 8'h7C);
    norm_key(8'h56, 8'h7B); norm_key(8'h57, 8'h79); norm_key(8'h59, 8'h69); norm_key(8'h5A, 8'h72);
    norm_key(8'h5B, 8'h7A); norm_key(8'h5C, 8'h6B); norm_key(8'h5D, 8'h73); norm_key(8'h5E, 8'h74);
    norm_key(8'h5F, 8'h6C); norm_key(8'h60, 8'h75); norm_key(8'h61, 8'h7D); norm_key(8'h62, 8'h70);
    norm_key(8'h63, 8'h71); norm_key(8'hE0, 8'h14); norm_key(8'hE1, 8'h12); norm_key(8'hE2, 8'h11);
    norm_key(8'hE5, 8'h59);
    ext_key(8'h49, 8'h70); ext_key(8'h4A, 8'h6C); ext_key(8'h4B, 8'h7D); ext_key(8'h4C, 8'h71);
    ext_key(8'h4D, 8'h69); ext_key(8'h4E, 8'h7A); ext_key(8'h4F, 8'h74); ext_key(8'h50, 8'h6B);
    ext_key(8'h51, 8'h72); ext_key(8'h52, 8'h75); ext_key(8'h54, 8'h4A); ext_key(8'h58, 8'h5A);
    ext_key(8'h65, 8'h2F); ext_key(8'hE3, 8'h1F); ext_key(8'hE4, 8'h14); ext_key(8'hE6, 8'h11);
    ext_key(8'hE7, 8'h27);

    // key, released, typed, byte count, bytes in send order
    add_row(8'h04, 1'b0, 1'b1, 1, {8'h1C});
    add_row(8'h04, 1'b1, 1'b1, 2, {BYTE_BREAK, 8'h1C});
    add_row(8'h00, 1'b0, 1'b1, 0, '0);
    add_row(8'hFF, 1'b1, 1'b1, 0, '0);
    add_row(8'hFF, 1'b0, 1'b1, 0, '0);
    add_row(8'h00, 1'b1, 1'b1, 0, '0);
    add_row(HID_PRTSC, 1'b0, 1'b1, 4, {BYTE_EXT0, BYTE_LSHFT, BYTE_EXT0, BYTE_KPMUL});
    add_row(HID_PRTSC, 1'b1, 1'b1, 6,
            {BYTE_EXT0, BYTE_BREAK, BYTE_KPMUL, BYTE_EXT0, BYTE_BREAK, BYTE_LSHFT});
    add_row(HID_PAUSE, 1'b0, 1'b1, 8, {BYTE_EXT1, BYTE_LCTRL, BYTE_NUML, BYTE_EXT1,
                                       BYTE_BREAK, BYTE_LCTRL, BYTE_BREAK, BYTE_NUML});
    add_row(HID_PAUSE, 1'b1, 1'b1, 0, '0);
    add_row(8'hE7, 1'b0, 1'b1, 2, {BYTE_EXT0, 8'h27});
    add_row(8'hE7, 1'b1, 1'b1, 3, {BYTE_EXT0, BYTE_BREAK, 8'h27});
    add_row(8'h40, 1'b0, 1'b1, 1, {8'h83});
    add_row(8'h40, 1'b1, 1'b0, 0, '0);
    add_row(8'h58, 1'b0, 1'b0, 0, '0);
    add_row(8'h58, 1'b1, 1'b0, 0, '0);
    add_row(8'hE0, 1'b0, 1'b0, 0, '0);
    add_row(8'h65, 1'b1, 1'b0, 0, '0);
    add_row(8'h32, 1'b0, 1'b0, 0, '0);
    add_row(8'h64, 1'b1, 1'b0, 0, '0);
    add_row(8'hE8, 1'b0, 1'b0, 0, '0);
    add_row(8'h80, 1'b1, 1'b0, 0, '0);
    add_row(8'h7F, 1'b0, 1'b0, 0, '0);
    add_row(HID_PAUSE, 1'b0, 1'b0, 0, '0);
    add_row(8'h1D, 1'b1, 1'b0, 0, '0);
    directed_rows = event_rows.size();

    for (int r = 0; r < RANDOM_EVENTS; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        k = HID_PRTSC;
      end else if (pick < 12) begin
        k = HID_PAUSE;
      end else if (pick < 80) begin
        do k = 8'($urandom_range(0, 255)); while (set2_map[k].kind == KIND_NONE);
      end else begin
        k = 8'($urandom_range(0, 255));
      end
      add_row(k, 1'($urandom_range(0, 1)), 1'b0, 0, '0);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = $urandom_range(1, 16);
    foreach (event_rows[i]) begin
      row = event_rows[i];
      if (i == directed_rows || $urandom_range(0, 39) == 0) begin
        start <= 1'b0;
        wait_drained();
      end else if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      start <= 1'b1;
      in_key_code <= row.key;
      in_released <= row.rel;
      do @(posedge clk); while (busy);
      accepted_events++;
      if (row.golden) begin
        n = row.n;
        seq = row.seq;
      end else begin
        n = predict_set2(row.key, row.rel, seq);
      end
      for (int j = 0; j < n; j++)
        pending_bytes.push_back('{seq[8*(n-1-j) +: 8], (j == n - 1)});
    end
    start <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ key_event_to_ps2_set2_bytes.f @@
sv/ke2ps2_pkg.sv
sv/ke2ps2_seq.sv
sv/key_event_to_ps2_set2_bytes.sv
bench/key_event_to_ps2_set2_bytes_test.sv
